>>> src/bba_pkg.sv
// Shared types, codes and constants of the buddy block allocator.
`default_nettype none

package bba_pkg;

    // Fixed field widths of the channels and the reset pool size
    localparam int REQ_BYTES_W  = 32;
    localparam int OFFSET_W     = 16;
    localparam int LEVEL_OUT_W  = 4;
    localparam int POOL_LOG2_W  = 5;
    localparam int POOL_LOG2_RST = 16;

    // Request codes
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Result status codes
    localparam logic STAT_DONE    = 1'b0;
    localparam logic STAT_REFUSED = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_SEED,
        S_IDLE,
        S_DECODE,
        S_A_LINK,
        S_SPLIT,
        S_R_HDR,
        S_M_RD,
        S_M_CHK,
        S_M_U1,
        S_M_U2,
        S_PUSH,
        S_PUSH2,
        S_FINISH
    } bba_state_t;

    // Decoder verdicts on a request
    typedef struct packed {
        logic alloc_refused;
        logic release_bad;
    } dec_flags_t;

    // Top level for a pool size, saturated to the legal range
    function automatic int top_of_pool(input int pool_log2, input int min_log2,
                                       input int max_log2);
        int p;
        p = pool_log2;
        if (p < min_log2 + 1) p = min_log2 + 1;
        if (p > max_log2) p = max_log2;
        return p - min_log2;
    endfunction

endpackage

`default_nettype wire

>>> src/bba_if.sv
// Channel interfaces of the buddy block allocator: request, response, configuration.
`default_nettype none

interface bba_req_if;
    import bba_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [REQ_BYTES_W-1:0] request_bytes;
    logic [OFFSET_W-1:0]    block_offset;
    modport source (output valid, req_type, request_bytes, block_offset, input ready);
    modport sink   (input valid, req_type, request_bytes, block_offset, output ready);
endinterface

interface bba_rsp_if;
    import bba_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   status;
    logic [OFFSET_W-1:0]    alloc_offset;
    logic [LEVEL_OUT_W-1:0] granted_level;
    modport source (output valid, status, alloc_offset, granted_level, input ready);
    modport sink   (input valid, status, alloc_offset, granted_level, output ready);
endinterface

interface bba_cfg_if;
    import bba_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [POOL_LOG2_W-1:0] pool_size_log2;
    modport source (output valid, pool_size_log2, input ready);
    modport sink   (input valid, pool_size_log2, output ready);
endinterface

`default_nettype wire

>>> src/bba_decode.sv
// Request decoder: size level, size refusal and release offset checks.
`default_nettype none

module bba_decode #(
    parameter int MIN_BLOCK_LOG2 = 4,
    parameter int HEADER_BYTES   = 24,
    parameter int NLEV           = 13,
    parameter int LVL_W          = 4,
    parameter int BLK_W          = 12
) (
    input  logic [bba_pkg::REQ_BYTES_W-1:0] request_bytes,
    input  logic [bba_pkg::OFFSET_W-1:0]    block_offset,
    input  logic [LVL_W-1:0]                top,
    output logic [LVL_W-1:0]                want,
    output logic [BLK_W-1:0]                rel_idx,
    output bba_pkg::dec_flags_t             flags
);
    import bba_pkg::*;

    logic [33:0]         need;
    logic [33:0]         pool;
    logic                hit;
    logic [OFFSET_W-1:0] off;
    logic [OFFSET_W-1:0] idx_w;
    logic                alloc_refused;
    logic                release_bad;

    // Pick the smallest level that holds the request plus header, capped at the top level
    always_comb
    begin
        need = 34'(request_bytes) + 34'(HEADER_BYTES);
        pool = 34'(1) << (int'(top) + MIN_BLOCK_LOG2);
        want = '0;
        hit  = 1'b0;
        for (int l = 0; l < NLEV; l++)
        begin
            if (!hit && (l >= int'(top) || (34'(1) << (l + MIN_BLOCK_LOG2)) >= need))
            begin
                want = LVL_W'(l);
                hit  = 1'b1;
            end
        end
        alloc_refused = (request_bytes == '0) || (need > pool);
    end

    // Check a release offset against header, alignment and pool bounds
    always_comb
    begin
        off   = block_offset - OFFSET_W'(HEADER_BYTES);
        idx_w = off >> MIN_BLOCK_LOG2;
        rel_idx = BLK_W'(idx_w);
        release_bad =
            (17'(block_offset) < 17'(HEADER_BYTES)) ||
            ((off & OFFSET_W'((1 << MIN_BLOCK_LOG2) - 1)) != '0) ||
            (33'(idx_w) >= (33'(1) << top));
    end

    // Collect the verdicts
    assign flags = '{alloc_refused: alloc_refused, release_bad: release_bad};

endmodule

`default_nettype wire

>>> src/buddy_block_allocator_core.sv
// Top level of the buddy block allocator: sequencer, header and link memories.
`default_nettype none

// Buddy allocator over a pool of 2^pool_size_log2 bytes in blocks of at least
// 2^MIN_BLOCK_LOG2 bytes. Block headers (live, free, level) sit in one memory and
// free-list links (next, prev) in another, both with a registered read. One request
// is handled at a time. An allocate pops the head of the lowest non-empty level at or
// above the wanted one and splits down level by level; a release reads the block
// header, then per level reads and checks the buddy, unlinks it and promotes the
// merged block, and last pushes the block onto its level list, a read-modify-write
// pass over the memories per level. The core returns to idle before the next
// request is taken. The result sits in an output register, so the next request is
// taken while it waits; the core stalls only when a second result is ready before
// the first has been taken. After reset and after each pool_size_log2 write the
// header memory is swept, one entry per cycle, and no request is taken meanwhile;
// configuration writes are always taken.
module buddy_block_allocator_core #(
    parameter int MAX_POOL_LOG2  = 16,
    parameter int MIN_BLOCK_LOG2 = 4,
    parameter int HEADER_BYTES   = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    bba_cfg_if.sink   cfg,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp
);
    import bba_pkg::*;

    localparam int NLEV    = MAX_POOL_LOG2 - MIN_BLOCK_LOG2 + 1;
    localparam int BLK_W   = MAX_POOL_LOG2 - MIN_BLOCK_LOG2;
    localparam int NBLK    = 1 << BLK_W;
    localparam int LVL_W   = $clog2(NLEV);
    localparam int TOP_RST = top_of_pool(POOL_LOG2_RST, MIN_BLOCK_LOG2, MAX_POOL_LOG2);

    typedef struct packed {
        logic             live;
        logic             free;
        logic [LVL_W-1:0] level;
    } hdr_t;

    typedef struct packed {
        logic             ok;
        logic [BLK_W-1:0] ptr;
    } lnk_t;

    typedef struct packed {
        lnk_t nxt;
        lnk_t prv;
    } link_t;

    bba_state_t state_reg, state_next;

    logic                   req_type_reg, req_type_next;
    logic [REQ_BYTES_W-1:0] bytes_reg, bytes_next;
    logic [OFFSET_W-1:0]    boff_reg, boff_next;
    logic [BLK_W-1:0]       idx_reg, idx_next;
    logic [LVL_W-1:0]       lv_reg, lv_next;
    logic [LVL_W-1:0]       want_reg, want_next;
    logic [BLK_W-1:0]       ohead_reg, ohead_next;
    logic [BLK_W-1:0]       clr_reg, clr_next;
    logic [LVL_W-1:0]       top_reg, top_next;

    logic                   res_status_reg, res_status_next;
    logic [OFFSET_W-1:0]    res_off_reg, res_off_next;
    logic [LEVEL_OUT_W-1:0] res_lvl_reg, res_lvl_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_status_reg, out_status_next;
    logic [OFFSET_W-1:0]    out_off_reg, out_off_next;
    logic [LEVEL_OUT_W-1:0] out_lvl_reg, out_lvl_next;

    logic [BLK_W-1:0] head_reg [NLEV];
    logic [BLK_W-1:0] head_next [NLEV];
    logic [NLEV-1:0]  head_ok_reg, head_ok_next;

    // Memories
    hdr_t  hdr_mem  [NBLK];
    link_t link_mem [NBLK];
    hdr_t  hdr_rd_reg;
    link_t link_rd_reg;

    logic             rd_en;
    logic [BLK_W-1:0] rd_addr;
    logic             hdr_we;
    logic [BLK_W-1:0] hdr_waddr;
    hdr_t             hdr_wdata;
    logic             nxt_we, prv_we;
    logic [BLK_W-1:0] link_waddr;
    lnk_t             nxt_wdata, prv_wdata;

    logic             head_we;
    logic [LVL_W-1:0] head_widx;
    logic [BLK_W-1:0] head_wptr;
    logic             head_wok;
    logic [LVL_W-1:0] head_ridx;
    logic [BLK_W-1:0] head_rptr;
    logic             head_rok;

    logic             cfg_fire, req_fire, out_load, fin_ok;
    logic [LVL_W-1:0] dec_want;
    logic [BLK_W-1:0] dec_idx;
    dec_flags_t       dec_flags;
    logic             found;
    logic [LVL_W-1:0] found_lv;
    logic [BLK_W-1:0] lv_bit;
    logic [BLK_W-1:0] lo_mask;
    logic             rel_reject;
    logic             buddy_ok;

    bba_decode #(
        .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
        .HEADER_BYTES   (HEADER_BYTES),
        .NLEV           (NLEV),
        .LVL_W          (LVL_W),
        .BLK_W          (BLK_W)
    ) u_decode (
        .request_bytes (bytes_reg),
        .block_offset  (boff_reg),
        .top           (top_reg),
        .want          (dec_want),
        .rel_idx       (dec_idx),
        .flags         (dec_flags)
    );

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;
    assign req_fire  = req.valid && req.ready;
    assign fin_ok    = !out_valid_reg || rsp.ready;
    assign out_load  = (state_reg == S_FINISH) && fin_ok;

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.alloc_offset  = out_off_reg;
    assign rsp.granted_level = out_lvl_reg;

    // Find the lowest non-empty level at or above the wanted one
    always_comb
    begin
        found    = 1'b0;
        found_lv = '0;
        for (int l = 0; l < NLEV; l++)
        begin
            if (!found && l >= int'(dec_want) && head_ok_reg[l])
            begin
                found    = 1'b1;
                found_lv = LVL_W'(l);
            end
        end
    end

    // Level head read, buddy bit and release checks
    always_comb
    begin
        head_ridx  = (state_reg == S_DECODE) ? found_lv : lv_reg;
        head_rptr  = head_reg[head_ridx];
        head_rok   = head_ok_reg[head_ridx];
        lv_bit     = BLK_W'(1) << lv_reg;
        lo_mask    = ~({BLK_W{1'b1}} << hdr_rd_reg.level);
        rel_reject = !hdr_rd_reg.live || hdr_rd_reg.free || (hdr_rd_reg.level > top_reg) ||
                     ((idx_reg & lo_mask) != '0);
        buddy_ok   = hdr_rd_reg.live && hdr_rd_reg.free && (hdr_rd_reg.level == lv_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (clr_reg == {BLK_W{1'b1}}) state_next = S_SEED;
            S_SEED:   state_next = S_IDLE;
            S_IDLE:   if (req_fire) state_next = S_DECODE;
            S_DECODE:
            begin
                if (req_type_reg == REQ_ALLOC)
                    state_next = (dec_flags.alloc_refused || !found) ? S_FINISH : S_A_LINK;
                else
                    state_next = dec_flags.release_bad ? S_FINISH : S_R_HDR;
            end
            S_A_LINK: state_next = S_SPLIT;
            S_SPLIT:  if (lv_reg <= want_reg) state_next = S_FINISH;
            S_R_HDR:  state_next = rel_reject ? S_FINISH : S_M_RD;
            S_M_RD:   state_next = (lv_reg < top_reg) ? S_M_CHK : S_PUSH;
            S_M_CHK:  state_next = buddy_ok ? S_M_U1 : S_PUSH;
            S_M_U1:   state_next = S_M_U2;
            S_M_U2:   state_next = S_M_RD;
            S_PUSH:   state_next = head_rok ? S_PUSH2 : S_FINISH;
            S_PUSH2:  state_next = S_FINISH;
            S_FINISH: if (fin_ok) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        if (cfg_fire) state_next = S_CLEAR;
    end

    // Datapath, memory controls and register updates
    always_comb
    begin
        req_type_next   = req_type_reg;
        bytes_next      = bytes_reg;
        boff_next       = boff_reg;
        idx_next        = idx_reg;
        lv_next         = lv_reg;
        want_next       = want_reg;
        ohead_next      = ohead_reg;
        clr_next        = clr_reg;
        top_next        = top_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_lvl_next    = res_lvl_reg;
        out_status_next = out_status_reg;
        out_off_next    = out_off_reg;
        out_lvl_next    = out_lvl_reg;
        out_valid_next  = out_valid_reg;

        req.ready  = (state_reg == S_IDLE);
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        hdr_we     = 1'b0;
        hdr_waddr  = idx_reg;
        hdr_wdata  = '0;
        nxt_we     = 1'b0;
        prv_we     = 1'b0;
        link_waddr = idx_reg;
        nxt_wdata  = '0;
        prv_wdata  = '0;
        head_we    = 1'b0;
        head_widx  = lv_reg;
        head_wptr  = '0;
        head_wok   = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                hdr_we    = 1'b1;
                hdr_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            S_SEED:
            begin
                hdr_we     = 1'b1;
                hdr_waddr  = '0;
                hdr_wdata  = '{live: 1'b1, free: 1'b1, level: top_reg};
                nxt_we     = 1'b1;
                prv_we     = 1'b1;
                link_waddr = '0;
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    req_type_next = req.req_type;
                    bytes_next    = req.request_bytes;
                    boff_next     = req.block_offset;
                end
            end
            S_DECODE:
            begin
                res_status_next = STAT_DONE;
                res_off_next    = '0;
                res_lvl_next    = '0;
                if (req_type_reg == REQ_ALLOC)
                begin
                    if (dec_flags.alloc_refused || !found)
                        res_status_next = STAT_REFUSED;
                    else
                    begin
                        idx_next  = head_rptr;
                        lv_next   = found_lv;
                        want_next = dec_want;
                        rd_en     = 1'b1;
                        rd_addr   = head_rptr;
                    end
                end
                else if (!dec_flags.release_bad)
                begin
                    idx_next = dec_idx;
                    rd_en    = 1'b1;
                    rd_addr  = dec_idx;
                end
            end
            S_A_LINK:
            begin
                // Pop the list head; the next entry becomes head
                head_we   = 1'b1;
                head_wptr = link_rd_reg.nxt.ptr;
                head_wok  = link_rd_reg.nxt.ok;
                if (link_rd_reg.nxt.ok)
                begin
                    prv_we     = 1'b1;
                    link_waddr = link_rd_reg.nxt.ptr;
                end
            end
            S_SPLIT:
            begin
                if (lv_reg > want_reg)
                begin
                    // Push the upper half on its (empty) level list
                    lv_next    = lv_reg - 1'b1;
                    hdr_we     = 1'b1;
                    hdr_waddr  = idx_reg ^ (BLK_W'(1) << lv_next);
                    hdr_wdata  = '{live: 1'b1, free: 1'b1, level: lv_next};
                    nxt_we     = 1'b1;
                    prv_we     = 1'b1;
                    link_waddr = hdr_waddr;
                    head_we    = 1'b1;
                    head_widx  = lv_next;
                    head_wptr  = hdr_waddr;
                    head_wok   = 1'b1;
                end
                else
                begin
                    hdr_we       = 1'b1;
                    hdr_wdata    = '{live: 1'b1, free: 1'b0, level: want_reg};
                    res_off_next = OFFSET_W'((64'(idx_reg) << MIN_BLOCK_LOG2) +
                                             64'(HEADER_BYTES));
                    res_lvl_next = LEVEL_OUT_W'(want_reg);
                end
            end
            S_R_HDR:
            begin
                lv_next = hdr_rd_reg.level;
            end
            S_M_RD:
            begin
                rd_en   = (lv_reg < top_reg);
                rd_addr = idx_reg ^ lv_bit;
            end
            S_M_U1:
            begin
                // Unlink the buddy: fix its predecessor or the head
                if (link_rd_reg.prv.ok)
                begin
                    nxt_we     = 1'b1;
                    link_waddr = link_rd_reg.prv.ptr;
                    nxt_wdata  = link_rd_reg.nxt;
                end
                else
                begin
                    head_we   = 1'b1;
                    head_wptr = link_rd_reg.nxt.ptr;
                    head_wok  = link_rd_reg.nxt.ok;
                end
                hdr_we    = 1'b1;
                hdr_waddr = idx_reg | lv_bit;
            end
            S_M_U2:
            begin
                // Fix the successor and promote the merged block
                if (link_rd_reg.nxt.ok)
                begin
                    prv_we     = 1'b1;
                    link_waddr = link_rd_reg.nxt.ptr;
                    prv_wdata  = link_rd_reg.prv;
                end
                idx_next  = idx_reg & ~lv_bit;
                lv_next   = lv_reg + 1'b1;
                hdr_we    = 1'b1;
                hdr_waddr = idx_next;
                hdr_wdata = '{live: 1'b1, free: 1'b1, level: lv_next};
            end
            S_PUSH:
            begin
                hdr_we     = 1'b1;
                hdr_wdata  = '{live: 1'b1, free: 1'b1, level: lv_reg};
                nxt_we     = 1'b1;
                prv_we     = 1'b1;
                nxt_wdata  = '{ok: head_rok, ptr: head_rptr};
                ohead_next = head_rptr;
                head_we    = 1'b1;
                head_wptr  = idx_reg;
                head_wok   = 1'b1;
            end
            S_PUSH2:
            begin
                prv_we     = 1'b1;
                link_waddr = ohead_reg;
                prv_wdata  = '{ok: 1'b1, ptr: idx_reg};
            end
            default:
            begin
            end
        endcase

        // Output register: drop on handoff, load on finish
        if (out_valid_reg && rsp.ready) out_valid_next = 1'b0;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_off_next    = res_off_reg;
            out_lvl_next    = res_lvl_reg;
        end

        // Level heads
        head_ok_next = head_ok_reg;
        for (int l = 0; l < NLEV; l++) head_next[l] = head_reg[l];
        if (head_we)
        begin
            head_next[head_widx]    = head_wptr;
            head_ok_next[head_widx] = head_wok;
        end

        // Rebuild on a configuration write
        if (cfg_fire)
        begin
            top_next = LVL_W'(top_of_pool(int'(cfg.pool_size_log2), MIN_BLOCK_LOG2,
                                          MAX_POOL_LOG2));
            clr_next = '0;
            for (int l = 0; l < NLEV; l++) head_next[l] = '0;
            head_ok_next = NLEV'(1) << top_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            top_reg       <= LVL_W'(TOP_RST);
            out_valid_reg <= 1'b0;
            head_ok_reg   <= NLEV'(1) << TOP_RST;
            for (int l = 0; l < NLEV; l++) head_reg[l] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
            head_ok_reg   <= head_ok_next;
            for (int l = 0; l < NLEV; l++) head_reg[l] <= head_next[l];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        bytes_reg      <= bytes_next;
        boff_reg       <= boff_next;
        idx_reg        <= idx_next;
        lv_reg         <= lv_next;
        want_reg       <= want_next;
        ohead_reg      <= ohead_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_lvl_reg    <= res_lvl_next;
        out_status_reg <= out_status_next;
        out_off_reg    <= out_off_next;
        out_lvl_reg    <= out_lvl_next;
    end

    // Header memory
    always_ff @(posedge clk)
    begin
        if (hdr_we) hdr_mem[hdr_waddr] <= hdr_wdata;
        if (rd_en) hdr_rd_reg <= hdr_mem[rd_addr];
    end

    // Link memory with separate next and prev field writes
    always_ff @(posedge clk)
    begin
        if (nxt_we) link_mem[link_waddr].nxt <= nxt_wdata;
        if (prv_we) link_mem[link_waddr].prv <= prv_wdata;
        if (rd_en) link_rd_reg <= link_mem[rd_addr];
    end

endmodule

`default_nettype wire
